@@ design/swt_pkg.sv @@
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types and codes for the software timer slot table: request kinds
// and the command bundle broadcast from the controller to the slot cells.
// ----------------------------------------------------------------------------
package swt_pkg;

    localparam int KIND_W = 3;
    localparam int SLOT_W = 4;
    localparam int TIME_W = 32;
    localparam int TAG_W  = 32;

    // request kinds carried in tuser
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REG     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNREG   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REARM   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PLAY    = 3'd4;

    // command broadcast to every cell; each cell also gets its own select
    typedef struct packed {
        logic              reg_en;
        logic              unreg_en;
        logic              rearm_en;
        logic [TIME_W-1:0] period;
        logic              one_shot;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] now;
    } swt_cmd_t;

endpackage

@@ design/swt_cell.sv @@
// ----------------------------------------------------------------------------
// swt_cell
// One timer slot: active mark, period, last-fire time, one-shot flag and
// tag, plus the scan token stage handed on to the next cell.
// ----------------------------------------------------------------------------
module swt_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  swt_pkg::swt_cmd_t                 cmd,
    input  logic                              sel,
    input  logic                              adv,
    input  logic                              tok_in,
    output logic                              tok_out,
    output logic                              hit,
    output logic [swt_pkg::TAG_W-1:0]         hit_tag
);
    import swt_pkg::*;

    logic              tok_reg;
    logic              active_reg;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] last_reg;
    logic              one_shot_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [TIME_W-1:0] elapsed;
    logic              due;
    logic              fire;
    logic              do_reg;

    // elapsed time modulo 2^32 against the period
    assign elapsed = cmd.now - last_reg;
    assign due     = active_reg && (elapsed > period_reg);
    assign hit     = tok_reg && due;
    assign fire    = hit && adv;
    assign do_reg  = sel && cmd.reg_en && !active_reg;

    assign tok_out = tok_reg;
    assign hit_tag = hit ? tag_reg : '0;

    // token stage and active mark
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg    <= 1'b0;
            active_reg <= 1'b0;
        end else begin
            if (adv) begin
                tok_reg <= tok_in;
            end
            if (do_reg) begin
                active_reg <= 1'b1;
            end else if (sel && cmd.unreg_en) begin
                active_reg <= 1'b0;
            end else if (fire && one_shot_reg) begin
                active_reg <= 1'b0;
            end
        end
    end

    // slot payload
    always_ff @(posedge aclk) begin
        if (do_reg) begin
            period_reg   <= cmd.period;
            one_shot_reg <= cmd.one_shot;
            tag_reg      <= cmd.tag;
        end
        if (do_reg || (sel && cmd.rearm_en) || fire) begin
            last_reg <= cmd.now;
        end
    end

endmodule

@@ design/software_timer_slot_table_top.sv @@
// ----------------------------------------------------------------------------
// software_timer_slot_table_top
// Timer slot table with a 32-bit time counter; a play scan walks a token
// along a row of slot cells and emits one transaction per fired slot.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser / tlast
// s_       in   slot, period, one_shot, tag (72 bits)   tuser: kind
// m_       out  fired_slot, fired_tag (40 bits)         tlast: last_of_scan
//
// tick, register, unregister and rearm complete in their accept cycle.
// a play scan holds the input through the accept cycle, the token's walk
// along the row, one cell per cycle while the scan is not stalled, and the
// flush state; the walk stalls while the output register is full and a
// new fire waits behind the held fire, and the flush for the final transaction.
// no input transaction is taken while a scan runs.
// reset clears the time counter, all active marks and the scan token.
// ----------------------------------------------------------------------------
module software_timer_slot_table_top #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // slot[3:0], period[35:4], one_shot[36], tag[68:37]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // fired_slot[3:0], fired_tag[35:4]
    output logic        m_tlast
);
    import swt_pkg::*;

    localparam int SELW = (SLOTS > 16) ? $clog2(SLOTS) : SLOT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

    state_t             state_reg, state_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic               pend_v_reg, pend_v_next;
    logic [SLOT_W-1:0]  pend_slot_reg, pend_slot_next;
    logic [TAG_W-1:0]   pend_tag_reg, pend_tag_next;
    logic               m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]  m_slot_reg, m_slot_next;
    logic [TAG_W-1:0]   m_tag_reg, m_tag_next;
    logic               m_last_reg, m_last_next;

    logic [KIND_W-1:0]  in_kind;
    logic [SLOT_W-1:0]  in_slot;
    logic               s_fire;
    logic               start;
    logic               out_free;
    logic               stall;
    logic               adv;
    swt_cmd_t           cmd;

    logic [SLOTS-1:0]   tok;
    logic [SLOTS-1:0]   hit;
    logic [TAG_W-1:0]   cell_tag [SLOTS];
    logic               hit_any;
    logic [SLOT_W-1:0]  hit_idx;
    logic [TAG_W-1:0]   hit_tag;

    // input unpacking
    assign in_kind  = s_tuser;
    assign in_slot  = s_tdata[3:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign start    = s_fire && (in_kind == KIND_PLAY);

    // command broadcast to the cells
    always_comb begin
        cmd.reg_en   = s_fire && (in_kind == KIND_REG);
        cmd.unreg_en = s_fire && (in_kind == KIND_UNREG);
        cmd.rearm_en = s_fire && (in_kind == KIND_REARM);
        cmd.period   = s_tdata[35:4];
        cmd.one_shot = s_tdata[36];
        cmd.tag      = s_tdata[68:37];
        cmd.now      = time_reg;
    end

    // row of slot cells, token chained from cell to cell
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic sel;
        logic tok_in;
        assign sel    = (SELW'(in_slot) == SELW'(i));
        if (i == 0) begin : g_head
            assign tok_in = start;
        end else begin : g_link
            assign tok_in = tok[i-1];
        end
        swt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .sel     (sel),
            .adv     (adv),
            .tok_in  (tok_in),
            .tok_out (tok[i]),
            .hit     (hit[i]),
            .hit_tag (cell_tag[i])
        );
    end

    // collect the single hit of the token cell
    always_comb begin
        hit_idx = '0;
        hit_tag = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit[i]) begin
                hit_idx = hit_idx | SLOT_W'(i);
            end
            hit_tag = hit_tag | cell_tag[i];
        end
    end
    assign hit_any = |hit;

    // scan pacing against the output register
    assign out_free = !m_valid_reg || m_tready;
    assign stall    = (state_reg == ST_SCAN) && hit_any && pend_v_reg && !out_free;
    assign adv      = start || ((state_reg == ST_SCAN) && !stall);

    // next-state logic
    always_comb begin
        state_next     = state_reg;
        time_next      = time_reg;
        pend_v_next    = pend_v_reg;
        pend_slot_next = pend_slot_reg;
        pend_tag_next  = pend_tag_reg;
        m_valid_next   = m_valid_reg;
        m_slot_next    = m_slot_reg;
        m_tag_next     = m_tag_reg;
        m_last_next    = m_last_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (in_kind)
                        KIND_TICK: time_next  = time_reg + 1'b1;
                        KIND_PLAY: state_next = ST_SCAN;
                        default:   ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (hit_any) begin
                        // hold each fire until the next shows whether it is the last
                        if (pend_v_reg) begin
                            m_valid_next = 1'b1;
                            m_slot_next  = pend_slot_reg;
                            m_tag_next   = pend_tag_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_v_next    = 1'b1;
                        pend_slot_next = hit_idx;
                        pend_tag_next  = hit_tag;
                    end
                    if (tok[SLOTS-1]) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_v_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_slot_next  = pend_slot_reg;
                    m_tag_next   = pend_tag_reg;
                    m_last_next  = 1'b1;
                    pend_v_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            time_reg    <= '0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            time_reg    <= time_next;
            pend_v_reg  <= pend_v_next;
            m_valid_reg <= m_valid_next;
        end
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        m_slot_reg    <= m_slot_next;
        m_tag_reg     <= m_tag_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_tag_reg, m_slot_reg};
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // at most one cell holds the scan token
    a_tok_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok))
        else $error("scan token in more than one cell");

    // a fire waits only while a scan is in progress
    a_pend_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_v_reg)
        else $error("pending fire left after scan");

    // cells fire only under the token of a running scan
    a_hit_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_any |-> (state_reg == ST_SCAN))
        else $error("slot hit outside a scan");

    // the token enters the row right after a play transaction
    a_tok_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> tok[0])
        else $error("scan token did not enter the first cell");
`endif

endmodule
